FILE: design/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the filter bank checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: assertion failed");

// Next-cycle implication that is also checked during reset.
`define ASSERT_NEXT_ANY(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("%m: assertion failed");

`endif

FILE: design/bqf_pkg.sv
// ----------------------------------------------------------------------------
// bqf_pkg
// Types, widths and register codes of the multiplexed biquad filter bank.
// ----------------------------------------------------------------------------
package bqf_pkg;

  localparam int ADC_CHANNELS_DEF   = 8;
  localparam int MAX_MUX_SLOTS_DEF  = 8;
  localparam int COEF_FRAC_BITS_DEF = 28;

  localparam int COEF_W    = 32;
  localparam int SAMPLE_W  = 16;
  localparam int Y_W       = 18;
  localparam int AMP_W     = 16;
  localparam int IDX_W     = 6;
  localparam int CH_W      = 3;
  localparam int SLOT_W    = 3;
  localparam int MUXN_W    = 4;
  localparam int CFG_IDX_W = 3;
  localparam int ACC_W     = 54;
  localparam int SQ_W      = 2 * Y_W;
  localparam int AMP_SHIFT = 18;

  localparam logic [MUXN_W-1:0] MUXN_RESET = 4'd8;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_COEF_B0      = 3'd0,
    CFG_COEF_B1      = 3'd1,
    CFG_COEF_B2      = 3'd2,
    CFG_COEF_A1      = 3'd3,
    CFG_COEF_A2      = 3'd4,
    CFG_MUX_CHANNELS = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic signed [COEF_W-1:0] b0;
    logic signed [COEF_W-1:0] b1;
    logic signed [COEF_W-1:0] b2;
    logic signed [COEF_W-1:0] a1;
    logic signed [COEF_W-1:0] a2;
  } coef_set_t;

  typedef struct packed {
    logic        [SAMPLE_W-1:0] x1;
    logic        [SAMPLE_W-1:0] x2;
    logic signed [Y_W-1:0]      y1;
    logic signed [Y_W-1:0]      y2;
  } hist_t;

endpackage

FILE: design/bqf_hist_mem.sv
// ----------------------------------------------------------------------------
// bqf_hist_mem
// Per-filter history store with a registered read port, one write port and a
// valid bit per entry so that entries not yet written read as zero.
// ----------------------------------------------------------------------------
module bqf_hist_mem #(
  parameter int DEPTH  = bqf_pkg::ADC_CHANNELS_DEF * bqf_pkg::MAX_MUX_SLOTS_DEF,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                rd_en,
  input  logic [ADDR_W-1:0]   rd_addr,
  output bqf_pkg::hist_t      rd_data,
  input  logic                wr_en,
  input  logic [ADDR_W-1:0]   wr_addr,
  input  bqf_pkg::hist_t      wr_data
);

  bqf_pkg::hist_t mem_r [DEPTH];
  bqf_pkg::hist_t rd_q_r;
  logic           rd_vld_r;
  logic [DEPTH-1:0] vld_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q_r <= mem_r[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld_r <= vld_r[rd_addr];
      end
    end
  end

  assign rd_data = rd_vld_r ? rd_q_r : '0;

endmodule

FILE: design/bqf_mac.sv
// ----------------------------------------------------------------------------
// bqf_mac
// Three-stage biquad arithmetic: five registered products, two registered
// partial sums, then rounding to 16 fraction bits with saturation.
// ----------------------------------------------------------------------------
module bqf_mac #(
  parameter int COEF_FRAC_BITS = bqf_pkg::COEF_FRAC_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 en,
  input  bqf_pkg::coef_set_t                   coef,
  input  logic        [bqf_pkg::SAMPLE_W-1:0]  x,
  input  bqf_pkg::hist_t                       hist,
  output logic signed [bqf_pkg::Y_W-1:0]       y
);

  localparam int PX_W = bqf_pkg::COEF_W + bqf_pkg::SAMPLE_W + 1;
  localparam int PY_W = bqf_pkg::COEF_W + bqf_pkg::Y_W;
  localparam int S_W  = PY_W + 1;
  localparam logic signed [bqf_pkg::ACC_W-1:0] HALF =
    bqf_pkg::ACC_W'(64'sd1 <<< (COEF_FRAC_BITS - 1));
  localparam logic signed [bqf_pkg::ACC_W-1:0] Q_MAX = bqf_pkg::ACC_W'(131071);
  localparam logic signed [bqf_pkg::ACC_W-1:0] Q_MIN = bqf_pkg::ACC_W'(-131072);

  logic signed [PX_W-1:0] p0_r, p1_r, p2_r, p0_nxt, p1_nxt, p2_nxt;
  logic signed [PY_W-1:0] p3_r, p4_r, p3_nxt, p4_nxt;
  logic signed [S_W-1:0]  sb_r, sa_r, sb_nxt, sa_nxt;
  logic signed [bqf_pkg::ACC_W-1:0] acc, q;
  logic signed [bqf_pkg::Y_W-1:0]   y_r, y_nxt;

  always_comb begin
    p0_nxt = coef.b0 * $signed({1'b0, x});
    p1_nxt = coef.b1 * $signed({1'b0, hist.x1});
    p2_nxt = coef.b2 * $signed({1'b0, hist.x2});
    p3_nxt = coef.a1 * hist.y1;
    p4_nxt = coef.a2 * hist.y2;
  end

  always_comb begin
    sb_nxt = S_W'(p0_r) + S_W'(p1_r) + S_W'(p2_r);
    sa_nxt = S_W'(p3_r) + S_W'(p4_r);
  end

  always_comb begin
    acc = bqf_pkg::ACC_W'(sb_r) - bqf_pkg::ACC_W'(sa_r) + HALF;
    q   = acc >>> COEF_FRAC_BITS;
    if (q > Q_MAX) begin
      y_nxt = Q_MAX[bqf_pkg::Y_W-1:0];
    end else if (q < Q_MIN) begin
      y_nxt = Q_MIN[bqf_pkg::Y_W-1:0];
    end else begin
      y_nxt = q[bqf_pkg::Y_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p0_r <= p0_nxt;
      p1_r <= p1_nxt;
      p2_r <= p2_nxt;
      p3_r <= p3_nxt;
      p4_r <= p4_nxt;
      sb_r <= sb_nxt;
      sa_r <= sa_nxt;
      y_r  <= y_nxt;
    end
  end

  assign y = y_r;

endmodule

FILE: design/bqf_amp.sv
// ----------------------------------------------------------------------------
// bqf_amp
// Amplitude path: registered square of the filter output, then rounding off
// the low 18 bits with saturation into the output register.
// ----------------------------------------------------------------------------
module bqf_amp (
  input  logic                                clk,
  input  logic                                en,
  input  logic signed [bqf_pkg::Y_W-1:0]      y,
  output logic        [bqf_pkg::AMP_W-1:0]    amplitude
);

  localparam int RND_W = bqf_pkg::SQ_W - bqf_pkg::AMP_SHIFT;

  logic signed [bqf_pkg::SQ_W-1:0] sq_r, sq_nxt;
  logic        [bqf_pkg::SQ_W-1:0] rnd;
  logic        [RND_W-1:0]         amp_full;
  logic        [bqf_pkg::AMP_W-1:0] amp_r, amp_nxt;

  always_comb begin
    sq_nxt   = y * y;
    rnd      = bqf_pkg::SQ_W'(sq_r) + (bqf_pkg::SQ_W'(1) << (bqf_pkg::AMP_SHIFT - 1));
    amp_full = rnd[bqf_pkg::SQ_W-1:bqf_pkg::AMP_SHIFT];
    if (amp_full > RND_W'({bqf_pkg::AMP_W{1'b1}})) begin
      amp_nxt = {bqf_pkg::AMP_W{1'b1}};
    end else begin
      amp_nxt = amp_full[bqf_pkg::AMP_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq_r  <= sq_nxt;
      amp_r <= amp_nxt;
    end
  end

  assign amplitude = amp_r;

endmodule

FILE: design/multiplexed_biquad_filter_bank.sv
// ----------------------------------------------------------------------------
// multiplexed_biquad_filter_bank
// Bank of direct-form-I biquads selected by converter channel and mux slot.
// ----------------------------------------------------------------------------
// Each input beat selects filter adc_channel * mux_channels + mux_slot and
// returns one beat with that index, the saturated Q2.16 output and its
// amplitude from the output registers after stages s1 to s5. The bank takes
// one beat per cycle while no result beat is stalled and no beat addresses a
// filter that is still in one of the four stages between the history read
// and its write-back; such a beat waits for that write-back. The whole
// pipeline holds while a result beat is stalled. The history of all filters
// is held in one single-port-write, registered-read memory whose entries
// read as zero until first written, so no clearing pass follows reset. Beats
// with an out-of-range channel or slot are accepted and give no result.
module multiplexed_biquad_filter_bank #(
  parameter int ADC_CHANNELS   = bqf_pkg::ADC_CHANNELS_DEF,
  parameter int MAX_MUX_SLOTS  = bqf_pkg::MAX_MUX_SLOTS_DEF,
  parameter int COEF_FRAC_BITS = bqf_pkg::COEF_FRAC_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic        [bqf_pkg::CH_W-1:0]       in_adc_channel,
  input  logic        [bqf_pkg::SLOT_W-1:0]     in_mux_slot,
  input  logic        [bqf_pkg::SAMPLE_W-1:0]   in_sample,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic        [bqf_pkg::IDX_W-1:0]      out_filter_index,
  output logic signed [bqf_pkg::Y_W-1:0]        out_filtered,
  output logic        [bqf_pkg::AMP_W-1:0]      out_amplitude,
  input  logic                                  cfg_wr_en,
  input  logic        [bqf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic        [bqf_pkg::COEF_W-1:0]     cfg_wdata
);

  localparam int DEPTH  = ADC_CHANNELS * MAX_MUX_SLOTS;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int IDXF_W = bqf_pkg::CH_W + bqf_pkg::MUXN_W;

  bqf_pkg::coef_set_t               coef_r;
  logic [bqf_pkg::MUXN_W-1:0]       muxn_r;
  logic [bqf_pkg::MUXN_W-1:0]       muxn_eff;

  logic                             in_range, hit, adv, accept;
  logic [IDXF_W-1:0]                in_idx_full;
  logic [bqf_pkg::IDX_W-1:0]        in_idx;

  logic                             s1_vld_r, s2_vld_r, s3_vld_r, s4_vld_r, s5_vld_r;
  logic [bqf_pkg::IDX_W-1:0]        s1_idx_r, s2_idx_r, s3_idx_r, s4_idx_r, s5_idx_r;
  logic [bqf_pkg::SAMPLE_W-1:0]     s1_x_r, s2_x_r, s3_x_r, s4_x_r;
  logic [bqf_pkg::SAMPLE_W-1:0]     s2_x1_r, s3_x1_r, s4_x1_r;
  logic signed [bqf_pkg::Y_W-1:0]   s2_y1_r, s3_y1_r, s4_y1_r, s5_y_r;

  bqf_pkg::hist_t                   rd_hist, wr_hist;
  logic signed [bqf_pkg::Y_W-1:0]   mac_y;

  logic                             out_valid_r;
  logic [bqf_pkg::IDX_W-1:0]        out_idx_r;
  logic signed [bqf_pkg::Y_W-1:0]   out_y_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_r <= '0;
      muxn_r <= bqf_pkg::MUXN_RESET;
    end else if (cfg_wr_en) begin
      case (bqf_pkg::cfg_reg_t'(cfg_index))
        bqf_pkg::CFG_COEF_B0:      coef_r.b0 <= cfg_wdata;
        bqf_pkg::CFG_COEF_B1:      coef_r.b1 <= cfg_wdata;
        bqf_pkg::CFG_COEF_B2:      coef_r.b2 <= cfg_wdata;
        bqf_pkg::CFG_COEF_A1:      coef_r.a1 <= cfg_wdata;
        bqf_pkg::CFG_COEF_A2:      coef_r.a2 <= cfg_wdata;
        bqf_pkg::CFG_MUX_CHANNELS: muxn_r    <= cfg_wdata[bqf_pkg::MUXN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (muxn_r == '0) begin
      muxn_eff = bqf_pkg::MUXN_W'(1);
    end else if (muxn_r > bqf_pkg::MUXN_W'(MAX_MUX_SLOTS)) begin
      muxn_eff = bqf_pkg::MUXN_W'(MAX_MUX_SLOTS);
    end else begin
      muxn_eff = muxn_r;
    end
    in_range    = ({1'b0, in_adc_channel} < bqf_pkg::MUXN_W'(ADC_CHANNELS)) &&
                  ({1'b0, in_mux_slot} < muxn_eff);
    in_idx_full = IDXF_W'(in_adc_channel) * IDXF_W'(muxn_eff) + IDXF_W'(in_mux_slot);
    in_idx      = in_idx_full[bqf_pkg::IDX_W-1:0];
  end

  // A filter still between its history read and its write-back blocks a new beat.
  always_comb begin
    hit = (s1_vld_r && (s1_idx_r == in_idx)) ||
          (s2_vld_r && (s2_idx_r == in_idx)) ||
          (s3_vld_r && (s3_idx_r == in_idx)) ||
          (s4_vld_r && (s4_idx_r == in_idx));
    adv      = !out_valid_r || !out_stall;
    in_stall = !adv || (in_range && hit);
    accept   = in_valid && !in_stall;
  end

  bqf_hist_mem #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (adv),
    .rd_addr (in_idx[ADDR_W-1:0]),
    .rd_data (rd_hist),
    .wr_en   (adv && s4_vld_r),
    .wr_addr (s4_idx_r[ADDR_W-1:0]),
    .wr_data (wr_hist)
  );

  bqf_mac #(
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_mac (
    .clk  (clk),
    .en   (adv),
    .coef (coef_r),
    .x    (s1_x_r),
    .hist (rd_hist),
    .y    (mac_y)
  );

  always_comb begin
    wr_hist.x1 = s4_x_r;
    wr_hist.x2 = s4_x1_r;
    wr_hist.y1 = mac_y;
    wr_hist.y2 = s4_y1_r;
  end

  bqf_amp u_amp (
    .clk       (clk),
    .en        (adv),
    .y         (mac_y),
    .amplitude (out_amplitude)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r    <= 1'b0;
      s2_vld_r    <= 1'b0;
      s3_vld_r    <= 1'b0;
      s4_vld_r    <= 1'b0;
      s5_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      s1_vld_r    <= accept && in_range;
      s2_vld_r    <= s1_vld_r;
      s3_vld_r    <= s2_vld_r;
      s4_vld_r    <= s3_vld_r;
      s5_vld_r    <= s4_vld_r;
      out_valid_r <= s5_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_idx_r  <= in_idx;
      s1_x_r    <= in_sample;
      s2_idx_r  <= s1_idx_r;
      s2_x_r    <= s1_x_r;
      s2_x1_r   <= rd_hist.x1;
      s2_y1_r   <= rd_hist.y1;
      s3_idx_r  <= s2_idx_r;
      s3_x_r    <= s2_x_r;
      s3_x1_r   <= s2_x1_r;
      s3_y1_r   <= s2_y1_r;
      s4_idx_r  <= s3_idx_r;
      s4_x_r    <= s3_x_r;
      s4_x1_r   <= s3_x1_r;
      s4_y1_r   <= s3_y1_r;
      s5_idx_r  <= s4_idx_r;
      s5_y_r    <= mac_y;
      out_idx_r <= s5_idx_r;
      out_y_r   <= s5_y_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_filter_index = out_idx_r;
  assign out_filtered     = out_y_r;

endmodule

FILE: design/bqf_port_checker.sv
// ----------------------------------------------------------------------------
// bqf_port_checker
// Port-level checks of the filter bank result channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bqf_port_checker (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                out_valid,
  input  logic                                out_stall,
  input  logic        [bqf_pkg::IDX_W-1:0]    out_filter_index,
  input  logic signed [bqf_pkg::Y_W-1:0]      out_filtered,
  input  logic        [bqf_pkg::AMP_W-1:0]    out_amplitude
);

  localparam int RND_W = bqf_pkg::SQ_W - bqf_pkg::AMP_SHIFT;

  logic signed [bqf_pkg::SQ_W-1:0]  sq;
  logic        [bqf_pkg::SQ_W-1:0]  rnd;
  logic        [RND_W-1:0]          amp_full;
  logic        [bqf_pkg::AMP_W-1:0] amp_exp;

  always_comb begin
    sq       = out_filtered * out_filtered;
    rnd      = bqf_pkg::SQ_W'(sq) + (bqf_pkg::SQ_W'(1) << (bqf_pkg::AMP_SHIFT - 1));
    amp_full = rnd[bqf_pkg::SQ_W-1:bqf_pkg::AMP_SHIFT];
    if (amp_full > RND_W'({bqf_pkg::AMP_W{1'b1}})) begin
      amp_exp = {bqf_pkg::AMP_W{1'b1}};
    end else begin
      amp_exp = amp_full[bqf_pkg::AMP_W-1:0];
    end
  end

  // The result channel is empty in the cycle after any reset cycle.
  `ASSERT_NEXT_ANY(a_idle_after_reset, clk, !rst_n, !out_valid)

  // A stalled beat holds until it is taken.
  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_filter_index) && $stable(out_filtered) && $stable(out_amplitude))

  // The amplitude always belongs to the filtered value of the same beat.
  `ASSERT_IMPLY(a_amp_match, clk, rst_n, out_valid, out_amplitude == amp_exp)

endmodule

bind multiplexed_biquad_filter_bank bqf_port_checker u_bqf_port_checker (.*);

FILE: tb/sv/multiplexed_biquad_filter_bank_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// multiplexed_biquad_filter_bank_tb
// Self-checking bench for the multiplexed biquad filter bank. A bit-exact
// model of the bank predicts every result beat. Directed tests cover reset
// state, rounding, each coefficient, saturation and the mux count limits.
// Random traffic then runs under several sender and receiver idling mixes.
// ----------------------------------------------------------------------------
module multiplexed_biquad_filter_bank_tb;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES   = 12;
  localparam int BANK_DEPTH     = bqf_pkg::ADC_CHANNELS_DEF * bqf_pkg::MAX_MUX_SLOTS_DEF;
  localparam int RANDOM_BEATS   = 320;

  localparam logic [bqf_pkg::CFG_IDX_W-1:0] CFG_UNUSED_A = 3'd6;
  localparam logic [bqf_pkg::CFG_IDX_W-1:0] CFG_UNUSED_B = 3'd7;

  localparam logic signed [bqf_pkg::COEF_W-1:0] COEF_MAX     = 32'sh7FFF_FFFF;
  localparam logic signed [bqf_pkg::COEF_W-1:0] COEF_MIN     = 32'sh8000_0000;
  localparam logic signed [bqf_pkg::COEF_W-1:0] COEF_ONE     = 32'sh1000_0000;
  localparam logic signed [bqf_pkg::COEF_W-1:0] COEF_HALF    = 32'sh0800_0000;
  localparam logic signed [bqf_pkg::COEF_W-1:0] COEF_QUARTER = 32'sh0400_0000;
  localparam logic signed [bqf_pkg::COEF_W-1:0] COEF_EIGHTH  = 32'sh0200_0000;

  localparam longint Y_MAX   = 131071;
  localparam longint Y_MIN   = -131072;
  localparam longint AMP_MAX = 65535;

  typedef struct {
    logic        [bqf_pkg::IDX_W-1:0] filter_index;
    logic signed [bqf_pkg::Y_W-1:0]   filtered;
    logic        [bqf_pkg::AMP_W-1:0] amplitude;
  } bank_result_t;

  logic                                 clk              = 1'b0;
  logic                                 rst_n            = 1'b0;
  logic                                 in_valid         = 1'b0;
  logic                                 in_stall;
  logic        [bqf_pkg::CH_W-1:0]      in_adc_channel   = '0;
  logic        [bqf_pkg::SLOT_W-1:0]    in_mux_slot      = '0;
  logic        [bqf_pkg::SAMPLE_W-1:0]  in_sample        = '0;
  logic                                 out_valid;
  logic                                 out_stall        = 1'b0;
  logic        [bqf_pkg::IDX_W-1:0]     out_filter_index;
  logic signed [bqf_pkg::Y_W-1:0]       out_filtered;
  logic        [bqf_pkg::AMP_W-1:0]     out_amplitude;
  logic                                 cfg_wr_en        = 1'b0;
  logic        [bqf_pkg::CFG_IDX_W-1:0] cfg_index        = '0;
  logic        [bqf_pkg::COEF_W-1:0]    cfg_wdata        = '0;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int failures       = 0;
  int idle_cycles    = 0;

  bank_result_t expected_results[$];
  bank_result_t head;

  logic signed [bqf_pkg::COEF_W-1:0]   bq_b0, bq_b1, bq_b2, bq_a1, bq_a2;
  logic        [bqf_pkg::MUXN_W-1:0]   bq_mux_count;
  logic        [bqf_pkg::SAMPLE_W-1:0] hist_x1 [BANK_DEPTH];
  logic        [bqf_pkg::SAMPLE_W-1:0] hist_x2 [BANK_DEPTH];
  logic signed [bqf_pkg::Y_W-1:0]      hist_y1 [BANK_DEPTH];
  logic signed [bqf_pkg::Y_W-1:0]      hist_y2 [BANK_DEPTH];

  multiplexed_biquad_filter_bank DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_adc_channel   (in_adc_channel),
    .in_mux_slot      (in_mux_slot),
    .in_sample        (in_sample),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_filter_index (out_filter_index),
    .out_filtered     (out_filtered),
    .out_amplitude    (out_amplitude),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void apply_register_write(
      input logic [bqf_pkg::CFG_IDX_W-1:0] idx,
      input logic [bqf_pkg::COEF_W-1:0] data);
    case (idx)
      bqf_pkg::CFG_COEF_B0:      bq_b0 = data;
      bqf_pkg::CFG_COEF_B1:      bq_b1 = data;
      bqf_pkg::CFG_COEF_B2:      bq_b2 = data;
      bqf_pkg::CFG_COEF_A1:      bq_a1 = data;
      bqf_pkg::CFG_COEF_A2:      bq_a2 = data;
      bqf_pkg::CFG_MUX_CHANNELS: bq_mux_count = data[bqf_pkg::MUXN_W-1:0];
      default: ;
    endcase
  endfunction

  function automatic int effective_mux_count();
    if (bq_mux_count == 0) return 1;
    if (bq_mux_count > bqf_pkg::MAX_MUX_SLOTS_DEF) return bqf_pkg::MAX_MUX_SLOTS_DEF;
    return int'(bq_mux_count);
  endfunction

  // Returns 1 and the result when the beat addresses a filter of the bank.
  function automatic bit filter_bank_step(input logic [bqf_pkg::CH_W-1:0] ch,
                                          input logic [bqf_pkg::SLOT_W-1:0] slot,
                                          input logic [bqf_pkg::SAMPLE_W-1:0] x,
                                          output bank_result_t res);
    int     muxn;
    int     idx;
    longint acc;
    longint q;
    longint amp;
    muxn = effective_mux_count();
    res  = '{default: '0};
    if (int'(ch) >= bqf_pkg::ADC_CHANNELS_DEF || int'(slot) >= muxn) return 1'b0;
    idx = int'(ch) * muxn + int'(slot);
    acc = longint'(bq_b0) * longint'(x)
        + longint'(bq_b1) * longint'(hist_x1[idx])
        + longint'(bq_b2) * longint'(hist_x2[idx])
        - longint'(bq_a1) * longint'(hist_y1[idx])
        - longint'(bq_a2) * longint'(hist_y2[idx]);
    q = (acc + (longint'(1) <<< (bqf_pkg::COEF_FRAC_BITS_DEF - 1)))
        >>> bqf_pkg::COEF_FRAC_BITS_DEF;
    if (q > Y_MAX) q = Y_MAX;
    if (q < Y_MIN) q = Y_MIN;
    hist_x2[idx] = hist_x1[idx];
    hist_x1[idx] = x;
    hist_y2[idx] = hist_y1[idx];
    hist_y1[idx] = bqf_pkg::Y_W'(q);
    amp = (q * q + (longint'(1) <<< (bqf_pkg::AMP_SHIFT - 1))) >>> bqf_pkg::AMP_SHIFT;
    if (amp > AMP_MAX) amp = AMP_MAX;
    res.filter_index = bqf_pkg::IDX_W'(idx);
    res.filtered     = bqf_pkg::Y_W'(q);
    res.amplitude    = bqf_pkg::AMP_W'(amp);
    return 1'b1;
  endfunction

  function automatic void check_field(input string field, input longint want,
                                      input longint got);
    if (want != got) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, want, got);
      failures++;
    end
  endfunction

  task automatic send_beat(input logic [bqf_pkg::CH_W-1:0] ch,
                           input logic [bqf_pkg::SLOT_W-1:0] slot,
                           input logic [bqf_pkg::SAMPLE_W-1:0] x, output bit hit);
    bank_result_t res;
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_adc_channel <= ch;
    in_mux_slot    <= slot;
    in_sample      <= x;
    do @(posedge clk); while (in_stall !== 1'b0);
    hit = filter_bank_step(ch, slot, x, res);
    if (hit) expected_results.push_back(res);
  endtask

  // Drops valid and waits until every predicted beat has come back.
  task automatic settle_bank(input int extra_cycles);
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (extra_cycles) @(posedge clk);
  endtask

  task automatic write_register(input logic [bqf_pkg::CFG_IDX_W-1:0] idx,
                                input logic [bqf_pkg::COEF_W-1:0] data);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    apply_register_write(idx, data);
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic write_coefficients(input logic [bqf_pkg::COEF_W-1:0] b0,
                                    input logic [bqf_pkg::COEF_W-1:0] b1,
                                    input logic [bqf_pkg::COEF_W-1:0] b2,
                                    input logic [bqf_pkg::COEF_W-1:0] a1,
                                    input logic [bqf_pkg::COEF_W-1:0] a2);
    settle_bank(DRAIN_CYCLES);
    write_register(bqf_pkg::CFG_COEF_B0, b0);
    write_register(bqf_pkg::CFG_COEF_B1, b1);
    write_register(bqf_pkg::CFG_COEF_B2, b2);
    write_register(bqf_pkg::CFG_COEF_A1, a1);
    write_register(bqf_pkg::CFG_COEF_A2, a2);
  endtask

  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected beat: expected none, actual index %0d filtered %0d amplitude %0d",
                 $time, out_filter_index, out_filtered, out_amplitude);
        failures++;
      end else begin
        head = expected_results.pop_front();
        check_field("filter_index", longint'(head.filter_index), longint'(out_filter_index));
        check_field("filtered", longint'(head.filtered), longint'(out_filtered));
        check_field("amplitude", longint'(head.amplitude), longint'(out_amplitude));
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_wr_en) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
        $display("%0t: watchdog expired with %0d beats outstanding", $time,
                 expected_results.size());
        $display("tb: failure");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  task automatic test_reset_state();
    bit hit;
    send_beat(3'd0, 3'd0, 16'h0000, hit);
    send_beat(3'd7, 3'd7, 16'hFFFF, hit);
    send_beat(3'd3, 3'd5, 16'h8000, hit);
  endtask

  task automatic test_rounding();
    bit hit;
    write_coefficients(COEF_HALF, '0, '0, '0, '0);
    send_beat(3'd0, 3'd1, 16'h0001, hit);
    write_coefficients(-COEF_HALF, '0, '0, '0, '0);
    send_beat(3'd0, 3'd2, 16'h0001, hit);
    send_beat(3'd0, 3'd3, 16'h0003, hit);
  endtask

  task automatic test_coefficients();
    bit hit;
    write_coefficients(COEF_ONE, -COEF_HALF, COEF_QUARTER, -COEF_QUARTER, COEF_EIGHTH);
    send_beat(3'd2, 3'd1, 16'hFFFF, hit);
    send_beat(3'd2, 3'd1, 16'h1234, hit);
    send_beat(3'd2, 3'd1, 16'h0000, hit);
    send_beat(3'd2, 3'd1, 16'hA5A5, hit);
    send_beat(3'd4, 3'd6, 16'h5A5A, hit);
  endtask

  task automatic test_saturation();
    bit hit;
    write_coefficients(COEF_MAX, '0, '0, '0, '0);
    send_beat(3'd1, 3'd1, 16'hFFFF, hit);
    write_coefficients(COEF_MIN, COEF_MIN, '0, COEF_MAX, COEF_MIN);
    send_beat(3'd1, 3'd2, 16'hFFFF, hit);
    send_beat(3'd1, 3'd2, 16'h0000, hit);
  endtask

  task automatic test_mux_count();
    bit hit;
    write_coefficients(COEF_ONE, COEF_HALF, '0, '0, '0);
    write_register(bqf_pkg::CFG_MUX_CHANNELS, 32'd0);
    send_beat(3'd5, 3'd0, 16'h4321, hit);
    send_beat(3'd5, 3'd3, 16'h4321, hit);
    settle_bank(DRAIN_CYCLES);
    write_register(bqf_pkg::CFG_MUX_CHANNELS, 32'd15);
    write_register(CFG_UNUSED_A, 32'hFFFF_FFFF);
    write_register(CFG_UNUSED_B, 32'hFFFF_FFFF);
    send_beat(3'd7, 3'd7, 16'hFFFF, hit);
    settle_bank(DRAIN_CYCLES);
    write_register(bqf_pkg::CFG_MUX_CHANNELS, 32'd3);
    send_beat(3'd2, 3'd2, 16'h0F0F, hit);
    send_beat(3'd2, 3'd3, 16'h0F0F, hit);
    settle_bank(DRAIN_CYCLES);
    write_register(bqf_pkg::CFG_MUX_CHANNELS, 32'd1);
    send_beat(3'd7, 3'd0, 16'h8001, hit);
  endtask

  task automatic run_random_phase(input int idle_pct, input int stall_pct,
                                  input bit pause_midway);
    logic [bqf_pkg::CH_W-1:0]     ch;
    logic [bqf_pkg::CH_W-1:0]     last_ch;
    logic [bqf_pkg::SLOT_W-1:0]   slot;
    logic [bqf_pkg::SLOT_W-1:0]   last_slot;
    logic [bqf_pkg::SAMPLE_W-1:0] x;
    logic [bqf_pkg::COEF_W-1:0]   c [5];
    int                           hits;
    int                           pick;
    int                           kind;
    bit                           hit;
    last_ch   = '0;
    last_slot = '0;
    for (int setting = 0; setting < 2; setting++) begin
      settle_bank(DRAIN_CYCLES);
      send_idle_pct  = idle_pct;
      recv_stall_pct = stall_pct;
      kind = $urandom_range(3);
      for (int k = 0; k < 5; k++) begin
        case (kind)
          0: c[k] = (k < 3)
                  ? bqf_pkg::COEF_W'(int'($urandom_range(268435456)) - 134217728)
                  : bqf_pkg::COEF_W'(int'($urandom_range(200000000)) - 100000000);
          1: c[k] = $urandom;
          2: case ($urandom_range(3))
               0: c[k] = COEF_MAX;
               1: c[k] = COEF_MIN;
               2: c[k] = COEF_ONE;
               default: c[k] = '0;
             endcase
          default: c[k] = (k == 0)
                        ? COEF_ONE
                        : bqf_pkg::COEF_W'(int'($urandom_range(20000000)) - 10000000);
        endcase
      end
      write_coefficients(c[0], c[1], c[2], c[3], c[4]);
      write_register(bqf_pkg::CFG_MUX_CHANNELS,
                     ($urandom_range(1) == 0) ? 32'd8 : $urandom);
      if ($urandom_range(3) == 0) write_register(CFG_UNUSED_A, $urandom);
      hits = 0;
      while (hits < RANDOM_BEATS / 2) begin
        pick = $urandom_range(99);
        if (pick < 10) begin
          ch   = bqf_pkg::CH_W'($urandom);
          slot = bqf_pkg::SLOT_W'($urandom);
        end else if (pick < 40) begin
          ch   = last_ch;
          slot = last_slot;
        end else begin
          ch   = bqf_pkg::CH_W'($urandom);
          slot = bqf_pkg::SLOT_W'($urandom_range(effective_mux_count() - 1));
        end
        if ($urandom_range(9) == 0) begin
          case ($urandom_range(3))
            0: x = 16'h0000;
            1: x = 16'hFFFF;
            2: x = 16'h8000;
            default: x = 16'h7FFF;
          endcase
        end else begin
          x = bqf_pkg::SAMPLE_W'($urandom);
        end
        send_beat(ch, slot, x, hit);
        last_ch   = ch;
        last_slot = slot;
        if (hit) begin
          hits++;
          if (pause_midway && setting == 0 && hits == RANDOM_BEATS / 4) settle_bank(0);
        end
      end
    end
  endtask

  task automatic test_random_traffic();
    run_random_phase(0, 0, 1'b0);
    run_random_phase(72, 0, 1'b1);
    run_random_phase(0, 72, 1'b0);
    run_random_phase(8, 8, 1'b1);
  endtask

  initial begin
    bq_b0 = '0;
    bq_b1 = '0;
    bq_b2 = '0;
    bq_a1 = '0;
    bq_a2 = '0;
    bq_mux_count = bqf_pkg::MUXN_RESET;
    for (int i = 0; i < BANK_DEPTH; i++) begin
      hist_x1[i] = '0;
      hist_x2[i] = '0;
      hist_y1[i] = '0;
      hist_y2[i] = '0;
    end
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_reset_state();
    test_rounding();
    test_coefficients();
    test_saturation();
    test_mux_count();
    test_random_traffic();

    send_idle_pct  = 0;
    recv_stall_pct = 0;
    settle_bank(2 * DRAIN_CYCLES);
    if (failures == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
